// ----- design/prescaled_timer_pwm_capture_defines.svh -----
// Assertion macros shared by the timer RTL files.
// No dependencies; each file that checks its own logic includes this header.
`ifndef PRESCALED_TIMER_PWM_CAPTURE_DEFINES_SVH
`define PRESCALED_TIMER_PWM_CAPTURE_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset
`define PTPC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptpc: same-cycle check failed");
// Next-cycle implication
`define PTPC_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptpc: next-cycle check failed");
`else
`define PTPC_ASSERT_IMP(label, clk, rst, ante, cons)
`define PTPC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ----- design/ptpc_pkg.sv -----
// Shared types and codes for the prescaled timer with PWM / capture channels.
// No dependencies; used by ptpc_core and prescaled_timer_pwm_capture.
package ptpc_pkg;

  // Default configuration
  localparam int DEF_CHANNELS      = 4;
  localparam int DEF_COUNTER_WIDTH = 16;

  // Word kinds
  typedef enum logic [1:0] {
    MODE_TICK  = 2'd0,
    MODE_WRITE = 2'd1,
    MODE_READ  = 2'd2,
    MODE_IDLE  = 2'd3
  } mode_e;

  // Register map
  typedef enum logic [3:0] {
    REG_CTRL   = 4'd0,
    REG_IRQEN  = 4'd1,
    REG_STATUS = 4'd2,
    REG_EVENT  = 4'd3,
    REG_MODE01 = 4'd4,
    REG_MODE23 = 4'd5,
    REG_CHEN   = 4'd6,
    REG_COUNT  = 4'd7,
    REG_PSC    = 4'd8,
    REG_RELOAD = 4'd9,
    REG_CMP0   = 4'd10,
    REG_CMP1   = 4'd11,
    REG_CMP2   = 4'd12,
    REG_CMP3   = 4'd13
  } reg_e;

  // Output compare modes (channel mode bits 6:4)
  typedef enum logic [2:0] {
    OC_FROZEN0    = 3'd0,
    OC_FROZEN1    = 3'd1,
    OC_FROZEN2    = 3'd2,
    OC_FROZEN3    = 3'd3,
    OC_FORCE_LOW  = 3'd4,
    OC_FORCE_HIGH = 3'd5,
    OC_PWM1       = 3'd6,
    OC_PWM2       = 3'd7
  } oc_mode_e;

  // Bit positions
  localparam int CTRL_CEN  = 0;
  localparam int CTRL_UDIS = 1;
  localparam int CTRL_URS  = 2;
  localparam int CTRL_OPM  = 3;
  localparam int IE_UIE    = 0;
  localparam int IE_UDE    = 1;
  localparam int CHEN_EN   = 0;
  localparam int CHEN_P    = 1;
  localparam int CHEN_NP   = 3;

  typedef struct packed {
    mode_e       mode;
    logic [3:0]  reg_index;
    logic [15:0] write_data;
    logic [3:0]  pin_levels;
  } item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        update_irq;
    logic        dma_request;
    logic [3:0]  channel_out;
    logic [3:0]  capture_flags;
  } result_t;

endpackage

// ----- design/ptpc_core.sv -----
// Timer state and the single-pass next-state logic for one word.
// Depends on ptpc_pkg and prescaled_timer_pwm_capture_defines.svh.
`include "prescaled_timer_pwm_capture_defines.svh"

module ptpc_core #(
  parameter int CHANNELS      = ptpc_pkg::DEF_CHANNELS,
  parameter int COUNTER_WIDTH = ptpc_pkg::DEF_COUNTER_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  ptpc_pkg::item_t   item,
  output ptpc_pkg::result_t result
);

  // Architectural state
  logic [COUNTER_WIDTH-1:0] counter, counter_next;
  logic [15:0]              psc_cnt, psc_cnt_next;
  logic [15:0]              psc_value, psc_value_next;
  logic [15:0]              psc_active, psc_active_next;
  logic [COUNTER_WIDTH-1:0] reload, reload_next;
  logic [3:0]               ctrl, ctrl_next;
  logic [1:0]               irq_en, irq_en_next;
  logic [4:0]               status, status_next;
  logic [7:0]               chan_mode [CHANNELS];
  logic [7:0]               chan_mode_next [CHANNELS];
  logic [3:0]               chan_en [CHANNELS];
  logic [3:0]               chan_en_next [CHANNELS];
  logic [COUNTER_WIDTH-1:0] compare [CHANNELS];
  logic [COUNTER_WIDTH-1:0] compare_next [CHANNELS];
  logic [3:0]               prev_pins, prev_pins_next;

  logic [CHANNELS-1:0] is_in;
  logic [CHANNELS-1:0] cap_hit;
  logic [15:0]         rd;
  logic                dma;
  logic [3:0]          chan_out;

  // Classify channels and detect selected pin edges
  always_comb begin
    for (int ch = 0; ch < CHANNELS; ch++) begin
      is_in[ch] = chan_mode[ch][1:0] != 2'd0;
      if (chan_en[ch][ptpc_pkg::CHEN_P] && chan_en[ch][ptpc_pkg::CHEN_NP]) begin
        cap_hit[ch] = item.pin_levels[ch] ^ prev_pins[ch];
      end else if (chan_en[ch][ptpc_pkg::CHEN_P]) begin
        cap_hit[ch] = !item.pin_levels[ch] && prev_pins[ch];
      end else begin
        cap_hit[ch] = item.pin_levels[ch] && !prev_pins[ch];
      end
    end
  end

  // Next state: capture first, then the tick, write or read
  always_comb begin
    counter_next    = counter;
    psc_cnt_next    = psc_cnt;
    psc_value_next  = psc_value;
    psc_active_next = psc_active;
    reload_next     = reload;
    ctrl_next       = ctrl;
    irq_en_next     = irq_en;
    status_next     = status;
    chan_mode_next  = chan_mode;
    chan_en_next    = chan_en;
    compare_next    = compare;
    prev_pins_next  = item.pin_levels;
    rd              = '0;
    dma             = 1'b0;

    // Latch the count on enabled input channels that saw their edge
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (is_in[ch] && chan_en[ch][ptpc_pkg::CHEN_EN] && cap_hit[ch]) begin
        compare_next[ch]  = counter;
        status_next[ch+1] = 1'b1;
      end
    end

    unique case (item.mode)
      ptpc_pkg::MODE_TICK: begin
        if (ctrl[ptpc_pkg::CTRL_CEN] && reload != '0) begin
          if (psc_cnt < psc_active) begin
            psc_cnt_next = psc_cnt + 16'd1;
          end else begin
            psc_cnt_next = '0;
            if (counter == reload) begin
              counter_next = '0;
              if (!ctrl[ptpc_pkg::CTRL_UDIS]) begin
                psc_active_next = psc_value;
                status_next[0]  = 1'b1;
                dma             = irq_en[ptpc_pkg::IE_UDE];
                if (ctrl[ptpc_pkg::CTRL_OPM]) begin
                  ctrl_next[ptpc_pkg::CTRL_CEN] = 1'b0;
                end
              end
            end else begin
              counter_next = counter + COUNTER_WIDTH'(1);
            end
            // Compare match on output channels
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if (!is_in[ch] && counter_next == compare[ch]) begin
                status_next[ch+1] = 1'b1;
              end
            end
          end
        end
      end
      ptpc_pkg::MODE_WRITE: begin
        unique case (item.reg_index)
          ptpc_pkg::REG_CTRL:   ctrl_next = item.write_data[3:0];
          ptpc_pkg::REG_IRQEN:  irq_en_next = {item.write_data[8], item.write_data[0]};
          ptpc_pkg::REG_STATUS: status_next = status_next & item.write_data[4:0];
          ptpc_pkg::REG_EVENT: begin
            // Channel events go before the update generate
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if (item.write_data[ch+1]) begin
                if (is_in[ch]) begin
                  compare_next[ch] = counter;
                end
                status_next[ch+1] = 1'b1;
              end
            end
            if (item.write_data[0]) begin
              counter_next = '0;
              psc_cnt_next = '0;
              if (!ctrl[ptpc_pkg::CTRL_UDIS]) begin
                psc_active_next = psc_value;
                if (!ctrl[ptpc_pkg::CTRL_URS]) begin
                  status_next[0] = 1'b1;
                  dma            = irq_en[ptpc_pkg::IE_UDE];
                end
              end
            end
          end
          ptpc_pkg::REG_MODE01: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if (ch < 2) begin
                chan_mode_next[ch] = item.write_data[(ch % 2) * 8 +: 8];
              end
            end
          end
          ptpc_pkg::REG_MODE23: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if (ch >= 2) begin
                chan_mode_next[ch] = item.write_data[(ch % 2) * 8 +: 8];
              end
            end
          end
          ptpc_pkg::REG_CHEN: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
              chan_en_next[ch] = item.write_data[ch * 4 +: 4];
            end
          end
          ptpc_pkg::REG_COUNT:  counter_next = COUNTER_WIDTH'(item.write_data);
          ptpc_pkg::REG_PSC:    psc_value_next = item.write_data;
          ptpc_pkg::REG_RELOAD: reload_next = COUNTER_WIDTH'(item.write_data);
          ptpc_pkg::REG_CMP0, ptpc_pkg::REG_CMP1,
          ptpc_pkg::REG_CMP2, ptpc_pkg::REG_CMP3: begin
            // Compare is read-only while the channel captures
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if (item.reg_index == 4'(ptpc_pkg::REG_CMP0) + 4'(ch) && !is_in[ch]) begin
                compare_next[ch] = COUNTER_WIDTH'(item.write_data);
              end
            end
          end
          default: ;
        endcase
      end
      ptpc_pkg::MODE_READ: begin
        unique case (item.reg_index)
          ptpc_pkg::REG_CTRL:   rd = {12'd0, ctrl};
          ptpc_pkg::REG_IRQEN:  rd = {7'd0, irq_en[1], 7'd0, irq_en[0]};
          ptpc_pkg::REG_STATUS: rd = {11'd0, status_next};
          ptpc_pkg::REG_MODE01: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if (ch < 2) begin
                rd[(ch % 2) * 8 +: 8] = chan_mode[ch];
              end
            end
          end
          ptpc_pkg::REG_MODE23: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if (ch >= 2) begin
                rd[(ch % 2) * 8 +: 8] = chan_mode[ch];
              end
            end
          end
          ptpc_pkg::REG_CHEN: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
              rd[ch * 4 +: 4] = chan_en[ch];
            end
          end
          ptpc_pkg::REG_COUNT:  rd = 16'(counter);
          ptpc_pkg::REG_PSC:    rd = psc_value;
          ptpc_pkg::REG_RELOAD: rd = 16'(reload);
          ptpc_pkg::REG_CMP0, ptpc_pkg::REG_CMP1,
          ptpc_pkg::REG_CMP2, ptpc_pkg::REG_CMP3: begin
            for (int ch = 0; ch < CHANNELS; ch++) begin
              if (item.reg_index == 4'(ptpc_pkg::REG_CMP0) + 4'(ch)) begin
                rd = 16'(compare_next[ch]);
              end
            end
          end
          default: rd = '0;
        endcase
      end
      ptpc_pkg::MODE_IDLE: ;
    endcase
  end

  // Channel output levels from the state this word leaves behind
  always_comb begin : out_levels
    logic lvl;
    chan_out = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      unique case (ptpc_pkg::oc_mode_e'(chan_mode_next[ch][6:4]))
        ptpc_pkg::OC_FORCE_HIGH: lvl = 1'b1;
        ptpc_pkg::OC_PWM1:       lvl = counter_next < compare_next[ch];
        ptpc_pkg::OC_PWM2:       lvl = !(counter_next < compare_next[ch]);
        default:                 lvl = 1'b0;
      endcase
      if (chan_mode_next[ch][1:0] == 2'd0 && chan_en_next[ch][ptpc_pkg::CHEN_EN]) begin
        chan_out[ch] = lvl ^ chan_en_next[ch][ptpc_pkg::CHEN_P];
      end
    end
  end

  assign result.read_data     = rd;
  assign result.update_irq    = status_next[0] && irq_en_next[ptpc_pkg::IE_UIE];
  assign result.dma_request   = dma;
  assign result.channel_out   = chan_out;
  assign result.capture_flags = status_next[4:1];

  // Commit the word's state change
  always_ff @(posedge clk) begin
    if (rst) begin
      counter    <= '0;
      psc_cnt    <= '0;
      psc_value  <= '0;
      psc_active <= '0;
      reload     <= '1;
      ctrl       <= '0;
      irq_en     <= '0;
      status     <= '0;
      prev_pins  <= '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
        chan_mode[ch] <= '0;
        chan_en[ch]   <= '0;
        compare[ch]   <= '0;
      end
    end else if (fire) begin
      counter    <= counter_next;
      psc_cnt    <= psc_cnt_next;
      psc_value  <= psc_value_next;
      psc_active <= psc_active_next;
      reload     <= reload_next;
      ctrl       <= ctrl_next;
      irq_en     <= irq_en_next;
      status     <= status_next;
      prev_pins  <= prev_pins_next;
      chan_mode  <= chan_mode_next;
      chan_en    <= chan_en_next;
      compare    <= compare_next;
    end
  end

  `PTPC_ASSERT_NXT(a_hold_without_word, clk, rst, !fire, $stable(counter) && $stable(status))
  `PTPC_ASSERT_IMP(a_dma_needs_ude, clk, rst, result.dma_request, irq_en[ptpc_pkg::IE_UDE])
  `PTPC_ASSERT_NXT(a_zero_reload_holds, clk, rst, fire && item.mode == ptpc_pkg::MODE_TICK && reload == '0, $stable(counter))

endmodule

// ----- design/prescaled_timer_pwm_capture.sv -----
// Top level of the prescaled timer: word input register, core, result register.
// Depends on ptpc_pkg, ptpc_core and prescaled_timer_pwm_capture_defines.svh.
//
// One word (timer tick, register write, register read or idle) is taken every
// clock while item_stall is low, and each gives exactly one result word, which
// moves from the input register into the result register when that register
// is free or draining. The whole state update for a word, including the
// prescaler, counter, reload, capture and compare logic, is one combinational
// pass in ptpc_core between the input register and the result register, so
// the sustained rate is one word per clock while the result is not stalled;
// the counter increment followed by the compare against each channel sets the
// critical path. A stalled result holds the result register, and one further
// word waits in the input register before item_stall rises.
`include "prescaled_timer_pwm_capture_defines.svh"

module prescaled_timer_pwm_capture #(
  parameter int CHANNELS      = ptpc_pkg::DEF_CHANNELS,
  parameter int COUNTER_WIDTH = ptpc_pkg::DEF_COUNTER_WIDTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  ptpc_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output ptpc_pkg::result_t result
);

  logic              in_valid_q;
  ptpc_pkg::item_t   in_q;
  logic              out_valid_q;
  ptpc_pkg::result_t out_q;
  ptpc_pkg::result_t core_res;
  logic              advance;
  logic              take;

  // Move a word into the result register when that register is free or draining
  assign advance    = in_valid_q && (!out_valid_q || !result_stall);
  assign item_stall = in_valid_q && !advance;
  assign take       = item_valid && !item_stall;

  ptpc_core #(
    .CHANNELS      (CHANNELS),
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_core (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_q),
    .result (core_res)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!result_stall) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (take) begin
      in_q <= item;
    end
    if (advance) begin
      out_q <= core_res;
    end
  end

  assign result_valid = out_valid_q;
  assign result       = out_q;

  `PTPC_ASSERT_IMP(a_stall_only_when_full, clk, rst, item_stall, in_valid_q && out_valid_q)
  `PTPC_ASSERT_NXT(a_advance_fills_result, clk, rst, advance, out_valid_q)
  `PTPC_ASSERT_NXT(a_stall_keeps_word, clk, rst, item_stall, in_valid_q)

endmodule

// ----- verif/prescaled_timer_pwm_capture_tb.sv -----
// Self-checking bench for the prescaled timer with PWM / input-capture channels.
// Drives tick, register write and register read words; predicts each result word.
// Depends on ptpc_pkg and the prescaled_timer_pwm_capture RTL.
`timescale 1ns / 1ps

module prescaled_timer_pwm_capture_tb;
  import ptpc_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PARK_CYCLES = 150;
  localparam int DRAIN_TAIL  = 8;
  localparam int IDLE_PCT    = 38;

  // Register indexes past the map; bus values for control, events and mode select
  localparam logic [3:0]  REG_SPARE_LO = 4'd14;
  localparam logic [3:0]  REG_SPARE_HI = 4'd15;
  localparam logic [15:0] CTRL_RUN     = 16'd1 << CTRL_CEN;
  localparam logic [15:0] CTRL_HOLD_UP = 16'd1 << CTRL_UDIS;
  localparam logic [15:0] CTRL_OVF_REQ = 16'd1 << CTRL_URS;
  localparam logic [15:0] CTRL_ONESHOT = 16'd1 << CTRL_OPM;
  localparam logic [15:0] EVT_UG       = 16'h0001;
  localparam logic [15:0] EVT_ALL_CH   = 16'h001e;
  localparam logic [1:0]  SEL_OUTPUT   = 2'd0;
  localparam logic [1:0]  SEL_INPUT    = 2'd1;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_stall;
  item_t   item_word = '0;
  logic    result_valid;
  logic    result_stall = 1'b0;
  result_t result;

  prescaled_timer_pwm_capture dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item_word),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Timer state as the block should hold it
  logic [15:0] tmr_count   = '0;
  logic [15:0] psc_count   = '0;
  logic [15:0] psc_preload = '0;
  logic [15:0] psc_live    = '0;
  logic [15:0] arr_value   = 16'hffff;
  logic [3:0]  ctrl_bits   = '0;
  logic [1:0]  ie_bits     = '0;
  logic [4:0]  sr_bits     = '0;
  logic [7:0]  ch_mode [4] = '{4{8'h00}};
  logic [3:0]  ch_en   [4] = '{4{4'h0}};
  logic [15:0] ch_ccr  [4] = '{4{16'h0000}};
  logic [3:0]  pins_seen   = '0;

  result_t     response_q [$];
  int unsigned mismatch_count = 0;
  int unsigned results_seen = 0;
  logic        in_idle_on = 1'b1;
  logic        out_idle_on = 1'b1;
  logic        park_req = 1'b0;
  logic [3:0]  pin_state = '0;

  function automatic logic ch_is_input(int c);
    return ch_mode[c][1:0] != SEL_OUTPUT;
  endfunction

  function automatic logic ch_level(int c);
    logic lvl;
    if (ch_is_input(c) || !ch_en[c][CHEN_EN]) return 1'b0;
    case (oc_mode_e'(ch_mode[c][6:4]))
      OC_FORCE_HIGH: lvl = 1'b1;
      OC_PWM1:       lvl = tmr_count < ch_ccr[c];
      OC_PWM2:       lvl = !(tmr_count < ch_ccr[c]);
      default:       lvl = 1'b0;
    endcase
    return lvl ^ ch_en[c][CHEN_P];
  endfunction

  // Latch the count on the selected pin edge of each enabled input channel
  function automatic void capture_pin_edges(logic [3:0] pins);
    logic hit;
    for (int c = 0; c < 4; c++) begin
      if (ch_is_input(c) && ch_en[c][CHEN_EN]) begin
        if (ch_en[c][CHEN_P] && ch_en[c][CHEN_NP]) hit = pins[c] != pins_seen[c];
        else if (ch_en[c][CHEN_P]) hit = !pins[c] && pins_seen[c];
        else hit = pins[c] && !pins_seen[c];
        if (hit) begin
          ch_ccr[c] = tmr_count;
          sr_bits[c + 1] = 1'b1;
        end
      end
    end
    pins_seen = pins;
  endfunction

  // Advance prescaler and counter by one timer clock; return the DMA pulse
  function automatic logic timer_tick();
    logic dma = 1'b0;
    if (!ctrl_bits[CTRL_CEN] || arr_value == 16'd0) return 1'b0;
    if (psc_count < psc_live) begin
      psc_count = psc_count + 16'd1;
      return 1'b0;
    end
    psc_count = '0;
    if (tmr_count == arr_value) begin
      tmr_count = '0;
      if (!ctrl_bits[CTRL_UDIS]) begin
        psc_live = psc_preload;
        sr_bits[0] = 1'b1;
        dma = ie_bits[IE_UDE];
        if (ctrl_bits[CTRL_OPM]) ctrl_bits[CTRL_CEN] = 1'b0;
      end
    end else begin
      tmr_count = tmr_count + 16'd1;
    end
    for (int c = 0; c < 4; c++)
      if (!ch_is_input(c) && tmr_count == ch_ccr[c]) sr_bits[c + 1] = 1'b1;
    return dma;
  endfunction

  function automatic logic timer_write(logic [3:0] idx, logic [15:0] wd);
    logic dma = 1'b0;
    int c;
    case (reg_e'(idx))
      REG_CTRL:   ctrl_bits = wd[3:0];
      REG_IRQEN:  ie_bits = {wd[8], wd[0]};
      REG_STATUS: sr_bits = sr_bits & wd[4:0];
      REG_EVENT: begin
        // channel events first, then the generated update
        for (c = 0; c < 4; c++) begin
          if (wd[c + 1]) begin
            if (ch_is_input(c)) ch_ccr[c] = tmr_count;
            sr_bits[c + 1] = 1'b1;
          end
        end
        if (wd[0]) begin
          tmr_count = '0;
          psc_count = '0;
          if (!ctrl_bits[CTRL_UDIS]) begin
            psc_live = psc_preload;
            if (!ctrl_bits[CTRL_URS]) begin
              sr_bits[0] = 1'b1;
              dma = ie_bits[IE_UDE];
            end
          end
        end
      end
      REG_MODE01: begin
        ch_mode[0] = wd[7:0];
        ch_mode[1] = wd[15:8];
      end
      REG_MODE23: begin
        ch_mode[2] = wd[7:0];
        ch_mode[3] = wd[15:8];
      end
      REG_CHEN:   for (c = 0; c < 4; c++) ch_en[c] = wd[4 * c +: 4];
      REG_COUNT:  tmr_count = wd;
      REG_PSC:    psc_preload = wd;
      REG_RELOAD: arr_value = wd;
      REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3: begin
        // compare is read-only while the channel captures
        c = int'(idx) - int'(REG_CMP0);
        if (!ch_is_input(c)) ch_ccr[c] = wd;
      end
      default: ;
    endcase
    return dma;
  endfunction

  function automatic logic [15:0] timer_read(logic [3:0] idx);
    case (reg_e'(idx))
      REG_CTRL:   return {12'd0, ctrl_bits};
      REG_IRQEN:  return {7'd0, ie_bits[IE_UDE], 7'd0, ie_bits[IE_UIE]};
      REG_STATUS: return {11'd0, sr_bits};
      REG_MODE01: return {ch_mode[1], ch_mode[0]};
      REG_MODE23: return {ch_mode[3], ch_mode[2]};
      REG_CHEN:   return {ch_en[3], ch_en[2], ch_en[1], ch_en[0]};
      REG_COUNT:  return tmr_count;
      REG_PSC:    return psc_preload;
      REG_RELOAD: return arr_value;
      REG_CMP0:   return ch_ccr[0];
      REG_CMP1:   return ch_ccr[1];
      REG_CMP2:   return ch_ccr[2];
      REG_CMP3:   return ch_ccr[3];
      default:    return 16'd0;
    endcase
  endfunction

  function automatic result_t timer_response(item_t w);
    result_t r;
    logic dma = 1'b0;
    r = '0;
    capture_pin_edges(w.pin_levels);
    case (w.mode)
      MODE_TICK:  dma = timer_tick();
      MODE_WRITE: dma = timer_write(w.reg_index, w.write_data);
      MODE_READ:  r.read_data = timer_read(w.reg_index);
      default: ;
    endcase
    for (int c = 0; c < 4; c++) r.channel_out[c] = ch_level(c);
    r.update_irq    = sr_bits[0] && ie_bits[IE_UIE];
    r.dma_request   = dma;
    r.capture_flags = sr_bits[4:1];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    mismatch_count++;
  endtask

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (!rst && item_valid && !item_stall) response_q.push_back(timer_response(item_word));
  end

  // Compare every accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (response_q.size() == 0) begin
        report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                  results_seen));
      end else begin
        want = response_q.pop_front();
        if (result.read_data !== want.read_data)
          report_mismatch($sformatf("word %0d read_data %h, expected %h",
                                    results_seen, result.read_data, want.read_data));
        if (result.update_irq !== want.update_irq)
          report_mismatch($sformatf("word %0d update_irq %b, expected %b",
                                    results_seen, result.update_irq, want.update_irq));
        if (result.dma_request !== want.dma_request)
          report_mismatch($sformatf("word %0d dma_request %b, expected %b",
                                    results_seen, result.dma_request, want.dma_request));
        if (result.channel_out !== want.channel_out)
          report_mismatch($sformatf("word %0d channel_out %b, expected %b",
                                    results_seen, result.channel_out, want.channel_out));
        if (result.capture_flags !== want.capture_flags)
          report_mismatch($sformatf("word %0d capture_flags %b, expected %b",
                                    results_seen, result.capture_flags,
                                    want.capture_flags));
      end
      results_seen++;
    end
  end

  // Stall the result side: a long park on request, else random or none
  int unsigned park_left = 0;
  always @(posedge clk) begin
    if (park_left != 0) begin
      result_stall <= 1'b1;
      park_left <= park_left - 1;
    end else if (park_req) begin
      result_stall <= 1'b1;
      park_left <= PARK_CYCLES - 1;
    end else if (out_idle_on) begin
      result_stall <= ($urandom_range(99) < IDLE_PCT);
    end else begin
      result_stall <= 1'b0;
    end
  end

  // End the run when nothing moves for too long
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, with random gaps ahead of it, and hold it until taken
  task automatic send_word(input item_t w);
    while (in_idle_on && $urandom_range(99) < IDLE_PCT) begin
      item_valid <= 1'b0;
      @(posedge clk);
    end
    item_valid <= 1'b1;
    item_word <= w;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  task automatic wait_drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (response_q.size() != 0) @(posedge clk);
  endtask

  function automatic item_t make_word(mode_e m, logic [3:0] idx, logic [15:0] wd);
    item_t w;
    w.mode = m;
    w.reg_index = idx;
    w.write_data = wd;
    w.pin_levels = pin_state;
    return w;
  endfunction

  function automatic logic [7:0] mode_byte(oc_mode_e oc, logic [1:0] sel);
    return {1'b0, oc, 2'b00, sel};
  endfunction

  task automatic do_tick(input logic [3:0] pins);
    pin_state = pins;
    send_word(make_word(MODE_TICK, 4'($urandom_range(15)), 16'($urandom)));
  endtask

  task automatic do_write(input logic [3:0] idx, input logic [15:0] wd);
    send_word(make_word(MODE_WRITE, idx, wd));
  endtask

  task automatic do_read(input logic [3:0] idx);
    send_word(make_word(MODE_READ, idx, 16'($urandom)));
  endtask

  // Mostly ticks; writes lean toward values that keep the timer cycling
  function automatic item_t random_word();
    item_t w;
    int unsigned pick;
    logic [15:0] span;
    pick = $urandom_range(99);
    if ($urandom_range(99) < 30) pin_state = 4'($urandom_range(15));
    w = make_word(MODE_TICK, 4'($urandom_range(15)), 16'($urandom));
    span = (arr_value == 16'd0 || arr_value > 16'd40) ? 16'd24 : arr_value + 16'd2;
    if (pick >= 58 && pick < 76) begin
      w.mode = MODE_READ;
    end else if (pick >= 76 && pick < 98) begin
      w.mode = MODE_WRITE;
      if ($urandom_range(9) != 0) begin
        case (reg_e'(w.reg_index))
          REG_CTRL: begin
            w.write_data[CTRL_CEN] = 1'b1;
            if ($urandom_range(9) < 7) w.write_data[CTRL_UDIS] = 1'b0;
            if ($urandom_range(9) < 7) w.write_data[CTRL_OPM] = 1'b0;
          end
          REG_EVENT:  w.write_data[0] = ($urandom_range(3) == 0);
          REG_MODE01, REG_MODE23: begin
            if ($urandom_range(1) != 0) w.write_data[1:0] = SEL_OUTPUT;
            if ($urandom_range(1) != 0) w.write_data[9:8] = SEL_OUTPUT;
          end
          REG_COUNT:  w.write_data = 16'($urandom_range(span));
          REG_PSC:    w.write_data = 16'($urandom_range(3));
          REG_RELOAD:
            w.write_data = ($urandom_range(19) == 0) ? 16'd0 : 16'($urandom_range(24, 1));
          REG_CMP0, REG_CMP1, REG_CMP2, REG_CMP3:
            w.write_data = 16'($urandom_range(span));
          default: ;
        endcase
      end
    end else if (pick >= 98) begin
      w.mode = MODE_IDLE;
    end
    return w;
  endfunction

  task automatic test_register_defaults();
    do_read(REG_RELOAD);
    do_read(REG_SPARE_HI);
  endtask

  // Channel 0 PWM1, 2 PWM2 inverted, 1 captures on either edge, 3 on falling
  task automatic test_capture_and_pwm();
    do_write(REG_MODE01, {mode_byte(OC_FROZEN0, SEL_INPUT), mode_byte(OC_PWM1, SEL_OUTPUT)});
    do_write(REG_MODE23, {mode_byte(OC_FROZEN0, SEL_INPUT), mode_byte(OC_PWM2, SEL_OUTPUT)});
    do_write(REG_CHEN, 16'h33b1);
    do_write(REG_CMP0, 16'd2);
    do_write(REG_CMP2, 16'd1);
    do_write(REG_CMP1, 16'hffff);
    do_write(REG_RELOAD, 16'd3);
    do_write(REG_CTRL, CTRL_RUN);
    do_tick(4'b0010);
    do_tick(4'b1010);
    do_tick(4'b0000);
    do_tick(4'b0000);
    do_tick(4'b0101);
  endtask

  task automatic test_update_events();
    do_write(REG_IRQEN, 16'hffff);
    do_write(REG_PSC, 16'd1);
    do_write(REG_EVENT, EVT_UG | EVT_ALL_CH);
    do_write(REG_STATUS, 16'h0000);
    do_write(REG_CTRL, CTRL_RUN | CTRL_OVF_REQ | CTRL_ONESHOT);
    do_write(REG_EVENT, EVT_UG);
    do_write(REG_CTRL, CTRL_RUN | CTRL_HOLD_UP);
    do_write(REG_EVENT, EVT_UG);
    // count above reload runs on and wraps with no update
    do_write(REG_COUNT, 16'hffff);
    do_tick(4'b0101);
    do_tick(4'b0101);
    // channel 1 on rising edge, channel 3 with NP alone
    do_write(REG_CHEN, 16'h9311);
    do_tick(4'b1010);
    do_write(REG_RELOAD, 16'h0000);
    do_tick(4'b0000);
    do_write(REG_SPARE_LO, 16'hffff);
    send_word(make_word(MODE_IDLE, REG_SPARE_LO, 16'h0000));
  endtask

  task automatic test_random_traffic(input int unsigned count);
    repeat (count) send_word(random_word());
  endtask

  task automatic test_steady_stream();
    in_idle_on = 1'b0;
    out_idle_on = 1'b0;
    repeat (300) send_word(random_word());
    in_idle_on = 1'b1;
    out_idle_on = 1'b1;
  endtask

  // Park the result side while words keep coming, so the input stalls
  task automatic test_backpressure();
    item_valid <= 1'b0;
    park_req <= 1'b1;
    @(posedge clk);
    park_req <= 1'b0;
    repeat (24) send_word(random_word());
    wait_drain();
  endtask

  task automatic test_pause_for_drain();
    repeat (3) begin
      repeat (12) send_word(random_word());
      wait_drain();
    end
  endtask

  initial begin : run
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_register_defaults();
    test_capture_and_pwm();
    test_update_events();
    test_random_traffic(1000);
    test_steady_stream();
    test_backpressure();
    test_pause_for_drain();
    test_random_traffic(240);
    wait_drain();
    repeat (DRAIN_TAIL) @(posedge clk);
    if (response_q.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", response_q.size()));
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
